### rtl/sen_pkg.sv
// shared types and constants for the scaled euclidean norm block
// no dependencies; imported by sen_fpu and scaled_euclidean_norm_unit
`timescale 1ns / 1ps

package sen_pkg;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_DIV  = 2'd2,
        OP_SQRT = 2'd3
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    localparam logic [63:0] DBL_ZERO     = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_SIGN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] DBL_QBIT     = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DBL_DEF_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] DBL_SQRT_NAN = 64'h7FF8_0000_0000_0000;

endpackage

### rtl/sen_fpu.sv
// shared bit-serial double unit: add (same sign), multiply, divide, square root
// rounds to nearest even; depends on sen_pkg
`timescale 1ns / 1ps

module sen_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  sen_pkg::fpu_req_t req,
    input  logic [63:0]       op_a,
    input  logic [63:0]       op_b,
    output logic              done,
    output logic [63:0]       result
);
    import sen_pkg::*;

    typedef enum logic [9:0] {
        F_IDLE   = 10'b00_0000_0001,
        F_NORMIN = 10'b00_0000_0010,
        F_MUL    = 10'b00_0000_0100,
        F_DIV    = 10'b00_0000_1000,
        F_SQRT   = 10'b00_0001_0000,
        F_ALIGN  = 10'b00_0010_0000,
        F_NORM   = 10'b00_0100_0000,
        F_DENORM = 10'b00_1000_0000,
        F_ROUND  = 10'b01_0000_0000,
        F_DONE   = 10'b10_0000_0000
    } fstate_t;

    fstate_t            state_reg, state_next;
    fpu_op_t            op_reg, op_next;
    logic               sign_reg, sign_next;
    logic [52:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic signed [12:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [125:0]       acc_reg, acc_next;
    logic [65:0]        rem_reg, rem_next;
    logic [62:0]        q_reg, q_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [12:0]        shamt_reg, shamt_next;
    logic [63:0]        sig_reg, sig_next;
    logic signed [12:0] exp_reg, exp_next;
    logic               stk_reg, stk_next;
    logic [63:0]        res_reg, res_next;

    // operand classification
    logic [10:0] a_exp, b_exp;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
    logic        spec_hit;
    logic [63:0] spec_val;

    assign a_exp  = op_a[62:52];
    assign b_exp  = op_b[62:52];
    assign a_nan  = (&a_exp) && (|op_a[51:0]);
    assign b_nan  = (&b_exp) && (|op_b[51:0]);
    assign a_inf  = (&a_exp) && !(|op_a[51:0]);
    assign b_inf  = (&b_exp) && !(|op_b[51:0]);
    assign a_zero = (op_a[62:0] == 63'd0);
    assign b_zero = (op_b[62:0] == 63'd0);
    assign sx     = op_a[63] ^ op_b[63];

    always_comb
    begin
        spec_hit = 1'b1;
        spec_val = DBL_ZERO;
        case (req.op)
            OP_SQRT:
            begin
                if (a_nan)
                    spec_val = op_a | DBL_QBIT;
                else if (a_inf)
                    spec_val = op_a[63] ? DBL_SQRT_NAN : op_a;
                else if (a_zero)
                    spec_val = op_a;
                else if (op_a[63])
                    spec_val = DBL_SQRT_NAN;
                else
                    spec_hit = 1'b0;
            end
            OP_MUL:
            begin
                if (a_nan)
                    spec_val = op_a | DBL_QBIT;
                else if (b_nan)
                    spec_val = op_b | DBL_QBIT;
                else if ((a_inf && b_zero) || (a_zero && b_inf))
                    spec_val = DBL_DEF_NAN;
                else if (a_inf || b_inf)
                    spec_val = {sx, 11'h7FF, 52'd0};
                else if (a_zero || b_zero)
                    spec_val = {sx, 63'd0};
                else
                    spec_hit = 1'b0;
            end
            OP_DIV:
            begin
                if (a_nan)
                    spec_val = op_a | DBL_QBIT;
                else if (b_nan)
                    spec_val = op_b | DBL_QBIT;
                else if ((a_inf && b_inf) || (a_zero && b_zero))
                    spec_val = DBL_DEF_NAN;
                else if (a_inf || b_zero)
                    spec_val = {sx, 11'h7FF, 52'd0};
                else if (b_inf || a_zero)
                    spec_val = {sx, 63'd0};
                else
                    spec_hit = 1'b0;
            end
            default:
            begin
                if (a_nan)
                    spec_val = op_a | DBL_QBIT;
                else if (b_nan)
                    spec_val = op_b | DBL_QBIT;
                else if (a_inf && b_inf && sx)
                    spec_val = DBL_DEF_NAN;
                else if (a_inf)
                    spec_val = op_a;
                else if (b_inf)
                    spec_val = op_b;
                else if (a_zero && b_zero)
                    spec_val = {op_a[63] & op_b[63], 63'd0};
                else if (a_zero)
                    spec_val = op_b;
                else if (b_zero)
                    spec_val = op_a;
                else
                    spec_hit = 1'b0;
            end
        endcase
    end

    // datapath temporaries
    logic [105:0]       prod;
    logic               ge;
    logic [54:0]        dq_rem;
    logic [65:0]        r2, tq, rn;
    logic [63:0]        low_op;
    logic signed [12:0] dexp, ex;
    logic [53:0]        m54, r54;
    logic [52:0]        rm;
    logic               g, s, inc;
    logic signed [12:0] e_adj, bexp13;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        sign_next  = sign_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        shamt_next = shamt_reg;
        sig_next   = sig_reg;
        exp_next   = exp_reg;
        stk_next   = stk_reg;
        res_next   = res_reg;
        prod       = '0;
        ge         = 1'b0;
        dq_rem     = '0;
        r2         = '0;
        tq         = '0;
        rn         = '0;
        low_op     = '0;
        dexp       = '0;
        ex         = '0;
        m54        = '0;
        r54        = '0;
        rm         = '0;
        g          = 1'b0;
        s          = 1'b0;
        inc        = 1'b0;
        e_adj      = '0;
        bexp13     = '0;

        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    stk_next = 1'b0;
                    ma_next  = {|a_exp, op_a[51:0]};
                    mb_next  = {|b_exp, op_b[51:0]};
                    ea_next  = (|a_exp) ? $signed({2'b00, a_exp}) - 13'sd1023 : -13'sd1022;
                    eb_next  = (|b_exp) ? $signed({2'b00, b_exp}) - 13'sd1023 : -13'sd1022;
                    case (req.op)
                        OP_MUL, OP_DIV: sign_next = sx;
                        OP_SQRT:        sign_next = 1'b0;
                        default:        sign_next = op_a[63];
                    endcase
                    if (spec_hit)
                    begin
                        res_next   = spec_val;
                        state_next = F_DONE;
                    end
                    else
                        state_next = F_NORMIN;
                end
            end
            F_NORMIN:
            begin
                // subnormal operands slide up one bit a cycle
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - 13'sd1;
                end
                if (!mb_reg[52] && op_reg != OP_SQRT)
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - 13'sd1;
                end
                if (ma_reg[52] && (mb_reg[52] || op_reg == OP_SQRT))
                begin
                    case (op_reg)
                        OP_MUL:
                        begin
                            acc_next   = '0;
                            cnt_next   = 6'd52;
                            state_next = F_MUL;
                        end
                        OP_DIV:
                        begin
                            rem_next   = {13'd0, ma_reg};
                            q_next     = '0;
                            cnt_next   = 6'd62;
                            state_next = F_DIV;
                        end
                        OP_SQRT:
                        begin
                            m54        = ea_reg[0] ? {ma_reg, 1'b0} : {1'b0, ma_reg};
                            ex         = ea_reg[0] ? ea_reg - 13'sd1 : ea_reg;
                            exp_next   = ex >>> 1;
                            acc_next   = {m54, 72'd0};
                            rem_next   = '0;
                            q_next     = '0;
                            cnt_next   = 6'd62;
                            state_next = F_SQRT;
                        end
                        default:
                        begin
                            dexp = ea_reg - eb_reg;
                            if (!dexp[12])
                            begin
                                sig_next   = {1'b0, ma_reg, 10'd0};
                                acc_next   = {62'd0, 1'b0, mb_reg, 10'd0};
                                shamt_next = dexp;
                                exp_next   = ea_reg;
                            end
                            else
                            begin
                                sig_next   = {1'b0, mb_reg, 10'd0};
                                acc_next   = {62'd0, 1'b0, ma_reg, 10'd0};
                                shamt_next = eb_reg - ea_reg;
                                exp_next   = eb_reg;
                            end
                            state_next = F_ALIGN;
                        end
                    endcase
                end
            end
            F_MUL:
            begin
                // shift-and-add, multiplier bits msb first
                prod     = {acc_reg[104:0], 1'b0} + (mb_reg[52] ? {53'd0, ma_reg} : 106'd0);
                acc_next = {20'd0, prod};
                mb_next  = {mb_reg[51:0], 1'b0};
                if (cnt_reg == 6'd0)
                begin
                    sig_next   = prod[105:42];
                    stk_next   = |prod[41:0];
                    exp_next   = ea_reg + eb_reg;
                    state_next = F_NORM;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            F_DIV:
            begin
                // restoring division, one quotient bit a cycle
                ge       = rem_reg[54:0] >= {2'b00, mb_reg};
                dq_rem   = ge ? rem_reg[54:0] - {2'b00, mb_reg} : rem_reg[54:0];
                q_next   = {q_reg[61:0], ge};
                rem_next = {10'd0, dq_rem[53:0], 2'b00} >> 1;
                if (cnt_reg == 6'd0)
                begin
                    sig_next   = {1'b0, q_reg[61:0], ge};
                    stk_next   = (dq_rem != 55'd0);
                    exp_next   = ea_reg - eb_reg;
                    state_next = F_NORM;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            F_SQRT:
            begin
                // digit-by-digit root, two radicand bits a cycle
                acc_next = {acc_reg[123:0], 2'b00};
                r2       = {rem_reg[63:0], acc_reg[125:124]};
                tq       = {1'b0, q_reg, 2'b01};
                ge       = r2 >= tq;
                rn       = ge ? r2 - tq : r2;
                rem_next = rn;
                q_next   = {q_reg[61:0], ge};
                if (cnt_reg == 6'd0)
                begin
                    sig_next   = {1'b0, q_reg[61:0], ge};
                    stk_next   = (rn != 66'd0);
                    state_next = F_NORM;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            F_ALIGN:
            begin
                low_op = acc_reg[63:0];
                if (shamt_reg == 13'd0 || low_op == 64'd0)
                begin
                    sig_next   = sig_reg + low_op;
                    state_next = F_NORM;
                end
                else
                begin
                    acc_next   = {62'd0, 1'b0, low_op[63:1]};
                    stk_next   = stk_reg | low_op[0];
                    shamt_next = shamt_reg - 13'd1;
                end
            end
            F_NORM:
            begin
                if (sig_reg[63])
                begin
                    sig_next = {1'b0, sig_reg[63:1]};
                    stk_next = stk_reg | sig_reg[0];
                    exp_next = exp_reg + 13'sd1;
                end
                else if (!sig_reg[62])
                begin
                    sig_next = {sig_reg[62:0], 1'b0};
                    exp_next = exp_reg - 13'sd1;
                end
                else
                    state_next = F_DENORM;
            end
            F_DENORM:
            begin
                // gradual underflow: shift right down to the minimum exponent
                if (exp_reg < -13'sd1022)
                begin
                    if (sig_reg == 64'd0)
                        exp_next = -13'sd1022;
                    else
                    begin
                        sig_next = {1'b0, sig_reg[63:1]};
                        stk_next = stk_reg | sig_reg[0];
                        exp_next = exp_reg + 13'sd1;
                    end
                end
                else
                    state_next = F_ROUND;
            end
            F_ROUND:
            begin
                g      = sig_reg[9];
                s      = (|sig_reg[8:0]) | stk_reg;
                inc    = g & (s | sig_reg[10]);
                r54    = {1'b0, sig_reg[62:10]} + {53'd0, inc};
                rm     = r54[53] ? r54[53:1] : r54[52:0];
                e_adj  = r54[53] ? exp_reg + 13'sd1 : exp_reg;
                bexp13 = e_adj + 13'sd1023;
                if (rm[52] && bexp13 >= 13'sd2047)
                    res_next = {sign_reg, 11'h7FF, 52'd0};
                else
                    res_next = {sign_reg, rm[52] ? bexp13[10:0] : 11'd0, rm[51:0]};
                state_next = F_DONE;
            end
            F_DONE:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        sign_reg  <= sign_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        ea_reg    <= ea_next;
        eb_reg    <= eb_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        shamt_reg <= shamt_next;
        sig_reg   <= sig_next;
        exp_reg   <= exp_next;
        stk_reg   <= stk_next;
        res_reg   <= res_next;
    end

    assign done   = (state_reg == F_DONE);
    assign result = res_reg;

endmodule

### rtl/scaled_euclidean_norm_unit.sv
// scaled euclidean norm of a stream of doubles, one beat per element
// a zero element needs no fpu operation; a nonzero element takes a divide
// (none for a nan against a zero scale), one or two multiplies and an add,
// and the last beat of a vector of two or more elements with stride on adds
// a square root and a multiply; subnormal operands and a subnormal result add
// shift steps; all run on the one bit-serial shared fpu; one element at a
// time; rst_n (async) clears scale to 0, sum to 1, stride on
`timescale 1ns / 1ps

module scaled_euclidean_norm_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] element
    input  logic        s_tlast,
    input  logic [0:0]  s_tuser,   // [0] empty_req
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] norm
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sen_pkg::*;

    localparam logic [2:0] ADDR_STRIDE = 3'd0;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_DIV  = 9'b0_0000_0010,
        S_SQ   = 9'b0_0000_0100,
        S_MULP = 9'b0_0000_1000,
        S_ADD  = 9'b0_0001_0000,
        S_FIN  = 9'b0_0010_0000,
        S_SQRT = 9'b0_0100_0000,
        S_MULN = 9'b0_1000_0000,
        S_OUT  = 9'b1_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic        stride_reg, stride_next;
    logic [63:0] scale_reg, scale_next;
    logic [63:0] sum_reg, sum_next;
    logic        one_reg, one_next;       // no element of this vector seen yet
    logic        single_reg, single_next;
    logic        lt_reg, lt_next;         // new magnitude exceeds the scale
    logic        last_reg, last_next;
    logic [63:0] absx_reg, absx_next;
    logic [63:0] t_reg, t_next;           // t, t^2, p, root, or pending norm
    logic        wait_reg, wait_next;     // fpu op in flight
    logic        ovalid_reg, ovalid_next;
    logic [63:0] odata_reg, odata_next;

    fpu_req_t    fpu_req;
    logic [63:0] fpu_a, fpu_b, fpu_res;
    logic        fpu_done, op_state;

    sen_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (fpu_req),
        .op_a   (fpu_a),
        .op_b   (fpu_b),
        .done   (fpu_done),
        .result (fpu_res)
    );

    // register port: pready tied high, writes land on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_STRIDE) ? {31'd0, stride_reg} : 32'd0;

    always_comb
    begin
        stride_next = stride_reg;
        if (psel && penable && pwrite && paddr == ADDR_STRIDE)
            stride_next = pwdata[0];
    end

    // operand steering for the shared unit
    assign op_state = (state_reg == S_DIV) || (state_reg == S_SQ) || (state_reg == S_MULP)
                   || (state_reg == S_ADD) || (state_reg == S_SQRT) || (state_reg == S_MULN);

    always_comb
    begin
        fpu_req.start = op_state && !wait_reg;
        fpu_req.op    = OP_ADD;
        fpu_a         = sum_reg;
        fpu_b         = t_reg;
        case (state_reg)
            S_DIV:
            begin
                fpu_req.op = OP_DIV;
                fpu_a      = lt_reg ? scale_reg : absx_reg;
                fpu_b      = lt_reg ? absx_reg : scale_reg;
            end
            S_SQ:
            begin
                fpu_req.op = OP_MUL;
                fpu_a      = t_reg;
                fpu_b      = t_reg;
            end
            S_MULP:
            begin
                fpu_req.op = OP_MUL;
                fpu_a      = sum_reg;
                fpu_b      = t_reg;
            end
            S_ADD:
            begin
                // p + 1 on a new maximum, else sum + t^2
                fpu_req.op = OP_ADD;
                fpu_a      = lt_reg ? t_reg : sum_reg;
                fpu_b      = lt_reg ? DBL_ONE : t_reg;
            end
            S_SQRT:
            begin
                fpu_req.op = OP_SQRT;
                fpu_a      = sum_reg;
                fpu_b      = DBL_ZERO;
            end
            S_MULN:
            begin
                fpu_req.op = OP_MUL;
                fpu_a      = scale_reg;
                fpu_b      = t_reg;
            end
            default:
            begin
                fpu_req.op = OP_ADD;
            end
        endcase
    end

    // element classification at accept time
    logic [63:0] in_abs;
    logic        in_nz, in_nan, sc_nan, in_lt;

    assign in_abs = s_tdata & ~DBL_SIGN;
    assign in_nz  = (in_abs != 64'd0);
    assign in_nan = (&in_abs[62:52]) && (|in_abs[51:0]);
    assign sc_nan = (&scale_reg[62:52]) && (|scale_reg[51:0]);
    // both operands are non-negative, so bit order equals numeric order
    assign in_lt  = !in_nan && !sc_nan && (scale_reg < in_abs);

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        scale_next  = scale_reg;
        sum_next    = sum_reg;
        one_next    = one_reg;
        single_next = single_reg;
        lt_next     = lt_reg;
        last_next   = last_reg;
        absx_next   = absx_reg;
        t_next      = t_reg;
        wait_next   = wait_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;

        if (m_tready)
            ovalid_next = 1'b0;

        if (fpu_req.start)
            wait_next = 1'b1;
        if (fpu_done)
            wait_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0])
                    begin
                        // empty vector: zero norm, drop partial state
                        scale_next = DBL_ZERO;
                        sum_next   = DBL_ONE;
                        one_next   = 1'b1;
                        t_next     = DBL_ZERO;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        single_next = one_reg;
                        one_next    = 1'b0;
                        last_next   = s_tlast;
                        absx_next   = in_abs;
                        lt_next     = in_lt;
                        if (!in_nz)
                            state_next = S_FIN;
                        else if (!in_lt && scale_reg == DBL_ZERO)
                        begin
                            // only a nan gets here: t is the element itself
                            t_next     = in_abs;
                            state_next = S_SQ;
                        end
                        else
                            state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (fpu_done)
                begin
                    t_next     = fpu_res;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (fpu_done)
                begin
                    t_next     = fpu_res;
                    state_next = lt_reg ? S_MULP : S_ADD;
                end
            end
            S_MULP:
            begin
                if (fpu_done)
                begin
                    t_next     = fpu_res;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (fpu_done)
                begin
                    sum_next = fpu_res;
                    if (lt_reg)
                        scale_next = absx_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (!stride_reg || single_reg)
                begin
                    t_next     = stride_reg ? absx_reg : DBL_ZERO;
                    scale_next = DBL_ZERO;
                    sum_next   = DBL_ONE;
                    one_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (fpu_done)
                begin
                    t_next     = fpu_res;
                    state_next = S_MULN;
                end
            end
            S_MULN:
            begin
                if (fpu_done)
                begin
                    t_next     = fpu_res;
                    scale_next = DBL_ZERO;
                    sum_next   = DBL_ONE;
                    one_next   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hand the norm to the output register once it is free
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = t_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            stride_reg <= 1'b1;
            scale_reg  <= DBL_ZERO;
            sum_reg    <= DBL_ONE;
            one_reg    <= 1'b1;
            wait_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            stride_reg <= stride_next;
            scale_reg  <= scale_next;
            sum_reg    <= sum_next;
            one_reg    <= one_next;
            wait_reg   <= wait_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        single_reg <= single_next;
        lt_reg     <= lt_next;
        last_reg   <= last_next;
        absx_reg   <= absx_next;
        t_reg      <= t_next;
        odata_reg  <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

endmodule
